### rtl/core/salsa_pkg.sv
// salsa20 shared types, constants and round helper functions
`timescale 1ns / 1ps

package salsa_pkg;

  // sigma constants ("expand 32-byte k")
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  // configuration register indexes
  localparam logic [2:0] REG_KEY01 = 3'd0;
  localparam logic [2:0] REG_KEY23 = 3'd1;
  localparam logic [2:0] REG_KEY45 = 3'd2;
  localparam logic [2:0] REG_KEY67 = 3'd3;
  localparam logic [2:0] REG_NONCE = 3'd4;

  // reset values of the key and nonce registers
  localparam logic [63:0] KEY01_RST = 64'h0706050403020100;
  localparam logic [63:0] KEY23_RST = 64'h0F0E0D0C0B0A0908;
  localparam logic [63:0] KEY45_RST = 64'h1716151413121110;
  localparam logic [63:0] KEY67_RST = 64'h1F1E1D1C1B1A1918;
  localparam logic [63:0] NONCE_RST = 64'h0000000000000000;

  // sixteen 32-bit state words
  typedef logic [15:0][31:0] state_t;

  // per-block data that rides along the round pipeline
  typedef struct packed {
    logic [63:0]      ctr;
    logic [7:0][63:0] data;
    logic             use_data;
    logic             last;
  } side_t;

  // rotate left by n bits
  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] tmp;
    tmp = {v, v} << n;
    return tmp[63:32];
  endfunction

  // rotation amount of quarter-round step k
  function automatic logic [4:0] rot_amt(input logic [1:0] k);
    logic [4:0] r;
    case (k)
      2'd0: r = 5'd7;
      2'd1: r = 5'd9;
      2'd2: r = 5'd13;
      default: r = 5'd18;
    endcase
    return r;
  endfunction

  // word index of position k (a, b, c, d) in quarter round q of a column or row round
  function automatic logic [3:0] qr_idx(input logic row, input logic [1:0] q,
                                        input logic [1:0] k);
    logic [15:0] set;
    case ({row, q})
      3'b000: set = {4'd12, 4'd8, 4'd4, 4'd0};
      3'b001: set = {4'd1, 4'd13, 4'd9, 4'd5};
      3'b010: set = {4'd6, 4'd2, 4'd14, 4'd10};
      3'b011: set = {4'd11, 4'd7, 4'd3, 4'd15};
      3'b100: set = {4'd3, 4'd2, 4'd1, 4'd0};
      3'b101: set = {4'd4, 4'd7, 4'd6, 4'd5};
      3'b110: set = {4'd9, 4'd8, 4'd11, 4'd10};
      default: set = {4'd14, 4'd13, 4'd12, 4'd15};
    endcase
    return set[{k, 2'b00} +: 4];
  endfunction

  // initial state from key, nonce and block counter
  function automatic state_t build_state(input logic [63:0] k01, input logic [63:0] k23,
                                         input logic [63:0] k45, input logic [63:0] k67,
                                         input logic [63:0] nonce, input logic [63:0] ctr);
    state_t s;
    s[0]  = SIGMA0;
    s[1]  = k01[31:0];
    s[2]  = k01[63:32];
    s[3]  = k23[31:0];
    s[4]  = k23[63:32];
    s[5]  = SIGMA1;
    s[6]  = nonce[31:0];
    s[7]  = nonce[63:32];
    s[8]  = ctr[31:0];
    s[9]  = ctr[63:32];
    s[10] = SIGMA2;
    s[11] = k45[31:0];
    s[12] = k45[63:32];
    s[13] = k67[31:0];
    s[14] = k67[63:32];
    s[15] = SIGMA3;
    return s;
  endfunction

endpackage

### rtl/core/salsa_step.sv
// one pipeline stage: one add-rotate-xor step of four parallel quarter rounds
`timescale 1ns / 1ps

module salsa_step import salsa_pkg::*; #(
  parameter bit          ROW  = 1'b0,
  parameter int unsigned STEP = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   vld_i,
  input  state_t st_i,
  input  side_t  side_i,
  output logic   vld_o,
  output state_t st_o,
  output side_t  side_o
);

  localparam logic [1:0] K_SRC1 = STEP[1:0];
  localparam logic [1:0] K_TGT  = 2'(STEP + 1);
  localparam logic [1:0] K_SRC2 = 2'(STEP + 3);

  state_t st_d;
  logic   vld_q;
  state_t st_q;
  side_t  side_q;

  // four quarter rounds touch disjoint words, so they update side by side
  always_comb begin
    logic [31:0] sum;
    logic [3:0]  tgt;
    logic [3:0]  s1;
    logic [3:0]  s2;
    st_d = st_i;
    for (int q = 0; q < 4; q++) begin
      tgt = qr_idx(ROW, 2'(q), K_TGT);
      s1  = qr_idx(ROW, 2'(q), K_SRC1);
      s2  = qr_idx(ROW, 2'(q), K_SRC2);
      sum = st_i[s1] + st_i[s2];
      st_d[tgt] = st_i[tgt] ^ rotl(sum, rot_amt(K_SRC1));
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    st_q   <= st_d;
    side_q <= side_i;
  end

  assign vld_o  = vld_q;
  assign st_o   = st_q;
  assign side_o = side_q;

endmodule

### rtl/core/salsa_core.sv
// chain of round steps covering all double rounds
`timescale 1ns / 1ps

module salsa_core import salsa_pkg::*; #(
  parameter int unsigned ROUNDS = 20
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   vld_i,
  input  state_t st_i,
  input  side_t  side_i,
  output logic   vld_o,
  output state_t st_o,
  output side_t  side_o
);

  // odd counts round up to a whole double round; eight steps per double round
  localparam int unsigned NDR  = (ROUNDS + 1) / 2;
  localparam int unsigned NSTG = NDR * 8;

  logic   vld  [NSTG+1];
  state_t st   [NSTG+1];
  side_t  side [NSTG+1];

  assign vld[0]  = vld_i;
  assign st[0]   = st_i;
  assign side[0] = side_i;

  // column round steps then row round steps
  for (genvar j = 0; j < NSTG; j++) begin : g_stg
    salsa_step #(
      .ROW  (((j / 4) % 2) == 1),
      .STEP (j % 4)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[j]),
      .st_i   (st[j]),
      .side_i (side[j]),
      .vld_o  (vld[j+1]),
      .st_o   (st[j+1]),
      .side_o (side[j+1])
    );
  end

  assign vld_o  = vld[NSTG];
  assign st_o   = st[NSTG];
  assign side_o = side[NSTG];

  // every block leaves exactly the pipeline depth after it enters
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |-> (vld_o == $past(vld_i, NSTG)))
    else $error("core valid out of step with input");

endmodule

### rtl/core/salsa20_ctr_block_cipher_top.sv
// salsa20 counter mode block cipher, fully pipelined top level
`timescale 1ns / 1ps

// Salsa20 counter mode: each start_i pulse (while busy_o is low) takes one
// 64-byte block and its 64-bit counter. A new block can enter every clock
// cycle while busy_o is low. The round pipeline has one register stage per
// add-rotate-xor step, eight per double round, followed by one stage for the
// feed-forward add and data xor. Results come out in order, each on the out
// ports for a single cycle marked by done_o; the receiver cannot stall, so it
// must take every word as it appears. busy_o is high only in the first cycle
// after reset. The user must write the key and nonce registers through the
// cfg channel only while no block is in flight; the block itself does not
// enforce it. Indexes beyond the nonce are ignored.

module salsa20_ctr_block_cipher_top import salsa_pkg::*; #(
  parameter int unsigned ROUNDS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // block input
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] block_counter_i,
  input  logic [63:0] data_0_i,
  input  logic [63:0] data_1_i,
  input  logic [63:0] data_2_i,
  input  logic [63:0] data_3_i,
  input  logic [63:0] data_4_i,
  input  logic [63:0] data_5_i,
  input  logic [63:0] data_6_i,
  input  logic [63:0] data_7_i,
  input  logic        use_data_i,
  input  logic        is_last_i,
  // result output
  output logic        done_o,
  output logic [63:0] out_0_o,
  output logic [63:0] out_1_o,
  output logic [63:0] out_2_o,
  output logic [63:0] out_3_o,
  output logic [63:0] out_4_o,
  output logic [63:0] out_5_o,
  output logic [63:0] out_6_o,
  output logic [63:0] out_7_o,
  output logic        last_out_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic        busy_q;
  logic [63:0] key01_q;
  logic [63:0] key23_q;
  logic [63:0] key45_q;
  logic [63:0] key67_q;
  logic [63:0] nonce_q;

  logic   in_vld;
  state_t in_st;
  side_t  in_side;
  logic   core_vld;
  state_t core_st;
  side_t  core_side;

  state_t           init_st;
  logic [7:0][63:0] res_d;
  logic             done_q;
  logic [7:0][63:0] res_q;
  logic             last_q;

  // busy for one cycle after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o      = busy_q;
  assign cfg_ready_o = ~busy_q;

  // key and nonce registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key01_q <= KEY01_RST;
      key23_q <= KEY23_RST;
      key45_q <= KEY45_RST;
      key67_q <= KEY67_RST;
      nonce_q <= NONCE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_KEY01: key01_q <= cfg_data_i;
        REG_KEY23: key23_q <= cfg_data_i;
        REG_KEY45: key45_q <= cfg_data_i;
        REG_KEY67: key67_q <= cfg_data_i;
        REG_NONCE: nonce_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input word into the round pipeline
  assign in_vld = start_i & ~busy_q;
  assign in_st  = build_state(key01_q, key23_q, key45_q, key67_q, nonce_q, block_counter_i);
  assign in_side.ctr      = block_counter_i;
  assign in_side.data     = {data_7_i, data_6_i, data_5_i, data_4_i,
                             data_3_i, data_2_i, data_1_i, data_0_i};
  assign in_side.use_data = use_data_i;
  assign in_side.last     = is_last_i;

  salsa_core #(
    .ROUNDS (ROUNDS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (in_vld),
    .st_i   (in_st),
    .side_i (in_side),
    .vld_o  (core_vld),
    .st_o   (core_st),
    .side_o (core_side)
  );

  // feed-forward add, little-endian packing and optional data xor
  assign init_st = build_state(key01_q, key23_q, key45_q, key67_q, nonce_q, core_side.ctr);

  always_comb begin
    logic [31:0] lo;
    logic [31:0] hi;
    for (int i = 0; i < 8; i++) begin
      lo = core_st[2*i] + init_st[2*i];
      hi = core_st[2*i+1] + init_st[2*i+1];
      res_d[i] = {hi, lo} ^ (core_side.use_data ? core_side.data[i] : 64'd0);
    end
  end

  // output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= core_vld;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    last_q <= core_side.last;
  end

  assign done_o     = done_q;
  assign out_0_o    = res_q[0];
  assign out_1_o    = res_q[1];
  assign out_2_o    = res_q[2];
  assign out_3_o    = res_q[3];
  assign out_4_o    = res_q[4];
  assign out_5_o    = res_q[5];
  assign out_6_o    = res_q[6];
  assign out_7_o    = res_q[7];
  assign last_out_o = last_q;

  // a finished block is strobed out in the next cycle
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_vld |=> done_o)
    else $error("finished block not strobed out");

  // no strobe without a finished block
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !core_vld |=> !done_o)
    else $error("result strobe without a block");

  // busy only right after reset
  a_busy_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("busy held past first cycle");

endmodule

### tb/salsa20_ctr_block_cipher_top_test.sv
// self-checking testbench for the salsa20 counter mode block cipher top level
`timescale 1ns / 1ps

module salsa20_ctr_block_cipher_top_test;
  import salsa_pkg::*;

  localparam int ROUND_COUNT = 20;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_PHASES = 6;
  localparam int BLOCKS_PER_PHASE = 175;
  localparam logic [2:0] REG_IDX_MAX = 3'h7;

  // one 64-byte block as the driver presents it
  typedef struct packed {
    logic [63:0]      ctr;
    logic [7:0][63:0] data;
    logic             use_data;
    logic             last;
    logic             drain;
  } block_req_t;

  // one result word of the block
  typedef struct packed {
    logic [7:0][63:0] text;
    logic             last;
  } block_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        start = 1'b0;
  block_req_t  drive_q = '0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic             busy;
  logic             done;
  logic [7:0][63:0] out_words;
  logic             last_out;
  logic             cfg_ready;

  // key and nonce as the block should hold them
  logic [63:0] cfg_shadow [0:4];

  block_req_t blocks_pending [$];
  block_res_t keystream_due [$];

  int blocks_queued = 0;
  int blocks_taken = 0;
  int blocks_checked = 0;
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 1;
  int gap_left = 0;
  logic in_took = 1'b0;

  salsa20_ctr_block_cipher_top #(
    .ROUNDS(ROUND_COUNT)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .block_counter_i(drive_q.ctr),
    .data_0_i       (drive_q.data[0]),
    .data_1_i       (drive_q.data[1]),
    .data_2_i       (drive_q.data[2]),
    .data_3_i       (drive_q.data[3]),
    .data_4_i       (drive_q.data[4]),
    .data_5_i       (drive_q.data[5]),
    .data_6_i       (drive_q.data[6]),
    .data_7_i       (drive_q.data[7]),
    .use_data_i     (drive_q.use_data),
    .is_last_i      (drive_q.last),
    .done_o         (done),
    .out_0_o        (out_words[0]),
    .out_1_o        (out_words[1]),
    .out_2_o        (out_words[2]),
    .out_3_o        (out_words[3]),
    .out_4_o        (out_words[4]),
    .out_5_o        (out_words[5]),
    .out_6_o        (out_words[6]),
    .out_7_o        (out_words[7]),
    .last_out_o     (last_out),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // clock
  always #1 clk = ~clk;

  // 32-bit rotate left
  function automatic logic [31:0] rotl32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // one add-rotate-xor quarter round on four state words
  function automatic state_t salsa_qround(state_t w, logic [3:0] ia, logic [3:0] ib,
                                         logic [3:0] ic, logic [3:0] id);
    w[ib] = w[ib] ^ rotl32(w[ia] + w[id], 7);
    w[ic] = w[ic] ^ rotl32(w[ib] + w[ia], 9);
    w[id] = w[id] ^ rotl32(w[ic] + w[ib], 13);
    w[ia] = w[ia] ^ rotl32(w[id] + w[ic], 18);
    return w;
  endfunction

  // keystream block for the current key and nonce, xored with data if asked
  function automatic block_res_t salsa_block_predict(block_req_t blk);
    state_t init;
    state_t w;
    block_res_t res;
    logic [63:0] ks;
    int dr;
    int i;
    init[0]  = SIGMA0;
    init[1]  = cfg_shadow[REG_KEY01][31:0];
    init[2]  = cfg_shadow[REG_KEY01][63:32];
    init[3]  = cfg_shadow[REG_KEY23][31:0];
    init[4]  = cfg_shadow[REG_KEY23][63:32];
    init[5]  = SIGMA1;
    init[6]  = cfg_shadow[REG_NONCE][31:0];
    init[7]  = cfg_shadow[REG_NONCE][63:32];
    init[8]  = blk.ctr[31:0];
    init[9]  = blk.ctr[63:32];
    init[10] = SIGMA2;
    init[11] = cfg_shadow[REG_KEY45][31:0];
    init[12] = cfg_shadow[REG_KEY45][63:32];
    init[13] = cfg_shadow[REG_KEY67][31:0];
    init[14] = cfg_shadow[REG_KEY67][63:32];
    init[15] = SIGMA3;
    w = init;
    // an odd round count still runs a whole double round at the end
    for (dr = 0; dr < (ROUND_COUNT + 1) / 2; dr++) begin
      w = salsa_qround(w, 4'd0, 4'd4, 4'd8, 4'd12);
      w = salsa_qround(w, 4'd5, 4'd9, 4'd13, 4'd1);
      w = salsa_qround(w, 4'd10, 4'd14, 4'd2, 4'd6);
      w = salsa_qround(w, 4'd15, 4'd3, 4'd7, 4'd11);
      w = salsa_qround(w, 4'd0, 4'd1, 4'd2, 4'd3);
      w = salsa_qround(w, 4'd5, 4'd6, 4'd7, 4'd4);
      w = salsa_qround(w, 4'd10, 4'd11, 4'd8, 4'd9);
      w = salsa_qround(w, 4'd15, 4'd12, 4'd13, 4'd14);
    end
    for (i = 0; i < 8; i++) begin
      ks = {w[2*i+1] + init[2*i+1], w[2*i] + init[2*i]};
      res.text[i] = blk.use_data ? (ks ^ blk.data[i]) : ks;
    end
    res.last = blk.last;
    return res;
  endfunction

  // random 64-bit value, biased toward the extremes now and then
  function automatic logic [63:0] rand64();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // random block with counters clustered near the carry points
  function automatic block_req_t rand_block();
    block_req_t blk;
    int i;
    case ($urandom_range(0, 9))
      0: blk.ctr = 64'($urandom_range(0, 255));
      1: blk.ctr = {$urandom, 32'hFFFF_FFF0 | 32'($urandom_range(0, 15))};
      2: blk.ctr = 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(0, 15));
      default: blk.ctr = {$urandom, $urandom};
    endcase
    for (i = 0; i < 8; i++) begin
      blk.data[i] = rand64();
    end
    blk.use_data = 1'($urandom_range(0, 1));
    blk.last = ($urandom_range(0, 3) == 0);
    blk.drain = 1'b0;
    return blk;
  endfunction

  // directed block with every data word the same
  function automatic block_req_t fixed_block(logic [63:0] ctr, logic [63:0] fill,
                                              logic use_data, logic last);
    block_req_t blk;
    int i;
    blk.ctr = ctr;
    for (i = 0; i < 8; i++) begin
      blk.data[i] = fill;
    end
    blk.use_data = use_data;
    blk.last = last;
    blk.drain = 1'b0;
    return blk;
  endfunction

  task automatic queue_block(block_req_t blk);
    blocks_pending.push_back(blk);
    blocks_queued++;
  endtask

  // wait until every queued block is taken and its word has been checked
  task automatic wait_drained();
    while (blocks_taken != blocks_queued || blocks_checked != blocks_taken) begin
      @(negedge clk);
    end
  endtask

  // one register write on the config channel
  task automatic cfg_write(int idx, logic [63:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx[2:0];
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    if (idx <= int'(REG_NONCE)) begin
      cfg_shadow[idx[2:0]] = value;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic cfg_write_all(logic [63:0] value);
    int idx;
    for (idx = int'(REG_KEY01); idx <= int'(REG_NONCE); idx++) begin
      cfg_write(idx, value);
    end
  endtask

  // driver: bursts of blocks with random gaps, optional drain before a block
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !in_took) begin
      // hold the block until taken
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (blocks_pending.size() != 0 &&
                 (!blocks_pending[0].drain || blocks_checked == blocks_taken)) begin
      drive_q <= blocks_pending.pop_front();
      start <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 16);
        gap_left <= $urandom_range(0, 10);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: predict on each accepted block, check each result word
  always @(posedge clk) begin : monitor_p
    block_res_t due;
    int i;
    in_took <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      keystream_due.push_back(salsa_block_predict(drive_q));
      blocks_taken <= blocks_taken + 1;
    end
    if (rst_n && done) begin
      if (keystream_due.size() == 0) begin
        $display("%0t: result word with no block outstanding", $time);
        errors++;
      end else begin
        due = keystream_due.pop_front();
        for (i = 0; i < 8; i++) begin
          if (out_words[i] !== due.text[i]) begin
            $display("%0t: out_%0d mismatch, expected %h, got %h",
                     $time, i, due.text[i], out_words[i]);
            errors++;
          end
        end
        if (last_out !== due.last) begin
          $display("%0t: last_out mismatch, expected %b, got %b",
                   $time, due.last, last_out);
          errors++;
        end
        blocks_checked <= blocks_checked + 1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("salsa20_ctr_block_cipher_top_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    block_req_t blk;
    int phase;
    int n;
    int drain_at;
    int idx;
    cfg_shadow[REG_KEY01] = KEY01_RST;
    cfg_shadow[REG_KEY23] = KEY23_RST;
    cfg_shadow[REG_KEY45] = KEY45_RST;
    cfg_shadow[REG_KEY67] = KEY67_RST;
    cfg_shadow[REG_NONCE] = NONCE_RST;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // reset key: counter extremes, keystream only and xor, last mark
    queue_block(fixed_block(64'h0, 64'h0, 1'b0, 1'b0));
    queue_block(fixed_block('1, '1, 1'b1, 1'b1));
    queue_block(fixed_block(64'h0000_0000_FFFF_FFFF, 64'h0, 1'b1, 1'b0));
    queue_block(fixed_block(64'hFFFF_FFFF_0000_0000, '1, 1'b0, 1'b1));
    queue_block(fixed_block(64'h1, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1, 1'b0));
    for (n = 0; n < 3; n++) begin
      queue_block(rand_block());
    end
    wait_drained();

    // all-zero key and nonce
    cfg_write_all('0);
    queue_block(fixed_block(64'h0, 64'h0, 1'b0, 1'b0));
    queue_block(fixed_block('1, '1, 1'b1, 1'b1));
    queue_block(rand_block());
    wait_drained();

    // all-ones key and nonce
    cfg_write_all('1);
    queue_block(fixed_block(64'h0, '1, 1'b1, 1'b0));
    queue_block(fixed_block('1, 64'h0, 1'b0, 1'b1));
    queue_block(rand_block());
    wait_drained();

    // writes past the nonce index must leave the key alone
    for (idx = int'(REG_NONCE) + 1; idx <= int'(REG_IDX_MAX); idx++) begin
      cfg_write(idx, {$urandom, $urandom});
    end
    queue_block(fixed_block(64'h0, 64'h0, 1'b0, 1'b0));
    queue_block(rand_block());
    queue_block(rand_block());
    wait_drained();

    // random phases, each with a new key (the reset key again in phase 2) and one pause for a full drain
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 2) begin
        cfg_write(int'(REG_KEY01), KEY01_RST);
        cfg_write(int'(REG_KEY23), KEY23_RST);
        cfg_write(int'(REG_KEY45), KEY45_RST);
        cfg_write(int'(REG_KEY67), KEY67_RST);
        cfg_write(int'(REG_NONCE), NONCE_RST);
      end else begin
        for (idx = int'(REG_KEY01); idx <= int'(REG_NONCE); idx++) begin
          cfg_write(idx, rand64());
        end
        if ($urandom_range(0, 1) == 1) begin
          cfg_write(int'($urandom_range(int'(REG_NONCE) + 1, int'(REG_IDX_MAX))),
                    {$urandom, $urandom});
        end
      end
      drain_at = $urandom_range(20, BLOCKS_PER_PHASE - 20);
      for (n = 0; n < BLOCKS_PER_PHASE; n++) begin
        blk = rand_block();
        blk.drain = (n == drain_at);
        queue_block(blk);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (keystream_due.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, keystream_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("salsa20_ctr_block_cipher_top_test: PASS");
    end else begin
      $display("salsa20_ctr_block_cipher_top_test: FAIL");
    end
    $finish;
  end

endmodule
